### hw/rtl/tsml_pkg.sv
`timescale 1ns / 1ps

package tsml_pkg;

    localparam int NODE_COUNT     = 4096;
    localparam int ALPHABET_SIZE  = 26;

    localparam int NODE_W         = $clog2(NODE_COUNT);
    localparam int USED_W         = NODE_W + 1;
    localparam int SLOT_COUNT     = NODE_COUNT * ALPHABET_SIZE;
    localparam int SLOT_W         = $clog2(SLOT_COUNT);

    localparam int SYM_W          = 5;
    localparam int IDX_W          = 16;
    localparam int LEN_W          = 10;
    localparam int ROOT_LEN_W     = 11;
    localparam int LINK_W         = NODE_W + SYM_W;

    localparam logic [IDX_W-1:0]      SENTINEL_INDEX = IDX_W'(1000);
    localparam logic [ROOT_LEN_W-1:0] MAX_LENGTH     = ROOT_LEN_W'(2047);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

endpackage

### hw/rtl/trie_shortest_match_lookup_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        request    i_in_valid / o_in_stall   i_cmd, i_symbol, i_last, i_word_index,
//                                                i_word_length
// out       result     o_out_valid / i_out_stall o_best_index, o_pool_full
//
// A request runs the walk step (slot address, child read, back-link read, decide,
// best-entry read and update on an insert hit, close, accept) and on the last symbol
// then reads the best index at the reached node.
// The child, back-link and best-entry memories each have one read port with registered
// data, so every step of the walk waits on the previous read.
// No clearing pass after reset: a child entry counts only if its node is below the fill
// count and that node's back-link names the current node and symbol.
// o_in_stall is high while a request is in work; a waiting result holds until taken.
module trie_shortest_match_lookup_unit
    import tsml_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_cmd,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic             i_last,
    input  logic [IDX_W-1:0] i_word_index,
    input  logic [LEN_W-1:0] i_word_length,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [IDX_W-1:0] o_best_index,
    output logic             o_pool_full
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_RD_CHILD,
        S_RD_LINK,
        S_DECIDE,
        S_RD_BEST,
        S_UPD_BEST,
        S_DONE,
        S_RD_RES,
        S_OUT
    } t_state;

    t_state r_state;

    logic [NODE_W-1:0] r_child_mem [SLOT_COUNT];
    logic [LINK_W-1:0] r_link_mem  [NODE_COUNT];
    logic [IDX_W-1:0]  r_bw_mem    [NODE_COUNT];
    logic [LEN_W-1:0]  r_bl_mem    [NODE_COUNT];

    logic [NODE_W-1:0]     r_child_rd;
    logic [LINK_W-1:0]     r_link_rd;
    logic [IDX_W-1:0]      r_bw_rd;
    logic [LEN_W-1:0]      r_bl_rd;

    logic                  r_cmd;
    logic [SYM_W-1:0]      r_sym;
    logic                  r_last;
    logic [IDX_W-1:0]      r_idx;
    logic [LEN_W-1:0]      r_len;

    logic [NODE_W-1:0]     r_cursor;
    logic [USED_W-1:0]     r_used;
    logic                  r_stopped;
    logic                  r_overflow;
    logic                  r_mid_word;
    logic [SLOT_W-1:0]     r_slot;
    logic [IDX_W-1:0]      r_root_word;
    logic [ROOT_LEN_W-1:0] r_root_len;

    logic                  r_out_valid;
    logic [IDX_W-1:0]      r_out_best;
    logic                  r_out_full;

    logic                  w_accept;
    logic                  w_start;
    logic                  w_sym_bad;
    logic [SLOT_W-1:0]     n_slot;
    logic                  w_hit;
    logic                  w_full;
    logic                  w_alloc;
    logic [NODE_W-1:0]     w_new_node;
    logic                  w_best_we;
    logic [NODE_W-1:0]     w_best_addr;
    logic                  w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_best_index = r_out_best;
    assign o_pool_full = r_out_full;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_start    = !r_mid_word;
    assign w_sym_bad  = (32'(i_symbol) >= 32'(ALPHABET_SIZE));
    assign n_slot     = SLOT_W'(r_cursor) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(r_sym);
    assign w_hit      = (r_child_rd != '0) && ({1'b0, r_child_rd} < r_used)
                        && (r_link_rd == {r_cursor, r_sym});
    assign w_full     = (r_used == USED_W'(NODE_COUNT));
    assign w_new_node = r_used[NODE_W-1:0];
    assign w_alloc    = (r_state == S_DECIDE) && (t_cmd'(r_cmd) == CMD_INSERT)
                        && !w_hit && !w_full;
    assign w_best_we  = w_alloc || ((r_state == S_UPD_BEST) && (r_len < r_bl_rd));
    assign w_best_addr = w_alloc ? w_new_node : r_cursor;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (w_alloc) begin
            r_child_mem[r_slot]    <= w_new_node;
            r_link_mem[w_new_node] <= {r_cursor, r_sym};
        end
        r_child_rd <= r_child_mem[r_slot];
        r_link_rd  <= r_link_mem[r_child_rd];
    end

    always_ff @(posedge i_clk) begin
        if (w_best_we) begin
            r_bw_mem[w_best_addr] <= r_idx;
            r_bl_mem[w_best_addr] <= r_len;
        end
        r_bw_rd <= r_bw_mem[r_cursor];
        r_bl_rd <= r_bl_mem[r_cursor];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_used      <= USED_W'(1);
            r_stopped   <= 1'b0;
            r_overflow  <= 1'b0;
            r_mid_word  <= 1'b0;
            r_root_word <= SENTINEL_INDEX;
            r_root_len  <= MAX_LENGTH;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd      <= i_cmd;
                        r_sym      <= i_symbol;
                        r_last     <= i_last;
                        r_idx      <= i_word_index;
                        r_len      <= i_word_length;
                        r_mid_word <= !i_last;
                        if (w_start && (t_cmd'(i_cmd) == CMD_INSERT)
                                && (r_root_len > {1'b0, i_word_length})) begin
                            r_root_word <= i_word_index;
                            r_root_len  <= {1'b0, i_word_length};
                        end
                        if (w_start) begin
                            r_cursor <= '0;
                        end
                        if (!w_start && r_stopped) begin
                            r_state <= S_DONE;
                        end else if (w_sym_bad) begin
                            r_stopped <= 1'b1;
                            r_state   <= S_DONE;
                        end else begin
                            r_stopped <= 1'b0;
                            r_state   <= S_ADDR;
                        end
                    end
                end
                S_ADDR: begin
                    r_slot  <= n_slot;
                    r_state <= S_RD_CHILD;
                end
                S_RD_CHILD: begin
                    r_state <= S_RD_LINK;
                end
                S_RD_LINK: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (w_hit) begin
                        r_cursor <= r_child_rd;
                        r_state  <= (t_cmd'(r_cmd) == CMD_INSERT) ? S_RD_BEST : S_DONE;
                    end else if (t_cmd'(r_cmd) == CMD_QUERY) begin
                        r_stopped <= 1'b1;
                        r_state   <= S_DONE;
                    end else if (w_full) begin
                        r_overflow <= 1'b1;
                        r_stopped  <= 1'b1;
                        r_state    <= S_DONE;
                    end else begin
                        r_cursor <= w_new_node;
                        r_used   <= r_used + USED_W'(1);
                        r_state  <= S_DONE;
                    end
                end
                S_RD_BEST: begin
                    r_state <= S_UPD_BEST;
                end
                S_UPD_BEST: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= r_last ? S_RD_RES : S_IDLE;
                end
                S_RD_RES: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_best  <= (r_cursor == '0) ? r_root_word : r_bw_rd;
                        r_out_full  <= r_overflow;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_cursor_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cursor} < r_used)
        else $error("cursor points past the allocated nodes");

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != '0) && (r_used <= USED_W'(NODE_COUNT)))
        else $error("node fill count out of range");

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |=> r_overflow)
        else $error("pool full flag cleared without reset");

    a_alloc_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alloc |=> (r_used == $past(r_used) + USED_W'(1)))
        else $error("node allocation did not advance the fill count");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && w_out_free |=> r_out_valid && $past(r_last))
        else $error("result produced for a symbol that is not last");

endmodule
